// ----- sv/ppr_pkg.sv -----
// ----------------------------------------------------------------------------
// ppr_pkg: shared types and helpers of the packed picture run decoder
// Holds the front-end phase encoding, the command that travels from the
// front end to the back end, and the small byte-lane helper functions.
// ----------------------------------------------------------------------------
package ppr_pkg;

  typedef enum logic [3:0] {
    PH_PREFIX,
    PH_MARKER,
    PH_TAG,
    PH_LITCNT,
    PH_PATCNT,
    PH_PATLOAD,
    PH_LITERAL,
    PH_FINAL,
    PH_DONE
  } phase_e;

  localparam logic [7:0] MARKER_BYTE = 8'hFF;
  localparam logic [7:0] CHUNK_BYTES = 8'd8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // One command: a run of len bytes built from word (repeated every eight
  // bytes), or a single status result when len is zero.
  typedef struct packed {
    logic [63:0] word;
    logic [7:0]  len;
    logic [12:0] fill;
    logic        plane;
    logic        pend;
    logic        pic;
    logic        bad;
  } cmd_t;

  function automatic logic [2:0] pattern_mask_f(input logic [1:0] sel);
    logic [2:0] m;
    case (sel)
      2'd0:    m = 3'd0;
      2'd1:    m = 3'd1;
      2'd2:    m = 3'd3;
      default: m = 3'd7;
    endcase
    return m;
  endfunction

  // Spread a pattern of 1, 2, 4 or 8 bytes over a whole 8-byte word.
  function automatic logic [63:0] replicate_f(input logic [63:0] w, input logic [2:0] m);
    logic [63:0] r;
    case (m)
      3'd0:    r = {8{w[7:0]}};
      3'd1:    r = {4{w[15:0]}};
      3'd3:    r = {2{w[31:0]}};
      default: r = w;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] keep_bytes_f(input logic [63:0] w, input logic [3:0] cnt);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < cnt) begin
        r[8*i +: 8] = w[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/ppr_front.sv -----
// ----------------------------------------------------------------------------
// ppr_front: stream parser of the packed picture run decoder
// Walks prefix, marker and tag records one byte per cycle unless stalled, keeps
// the plane byte count and makes one command per pattern run or literal byte.
// ----------------------------------------------------------------------------
module ppr_front
  import ppr_pkg::*;
#(
  parameter int PLANE_BYTES  = 7680,
  parameter int PREFIX_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       two_planes_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  input  logic       end_of_stream_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam int CNT_W  = $clog2(PLANE_BYTES + 1);
  localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
  localparam int PREF_W = $clog2(PREFIX_BYTES + 2);
  localparam logic [CNT_W-1:0] PLANE_C = CNT_W'(PLANE_BYTES);

  phase_e              phase_q, phase_d;
  logic [PREF_W-1:0]   prefix_left_q, prefix_left_d;
  logic [7:0]          run_left_q, run_left_d;
  logic [63:0]         store_q, store_d;
  logic [2:0]          mask_q, mask_d;
  logic [3:0]          fill_q, fill_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                plane_q, plane_d;

  logic                accept;
  logic                last_plane;
  logic [CMP_W-1:0]    room;
  logic [63:0]         store_new;
  logic [63:0]         em_word;
  logic [7:0]          em_n;
  logic [7:0]          n_eff;
  logic [CNT_W-1:0]    count_after;
  logic                full_after;
  logic                rec_end;
  logic                rec_full;

  assign in_stall_o = queue_full_i || (phase_q == PH_FINAL);
  assign accept     = in_valid_i && !in_stall_o;
  assign last_plane = !(two_planes_i && !plane_q);
  assign room       = CMP_W'(PLANE_C) - CMP_W'(count_q);

  always_comb begin
    store_new = store_q;
    for (int i = 0; i < 8; i++) begin
      if (fill_q[2:0] == 3'(i)) begin
        store_new[8*i +: 8] = stream_byte_i;
      end
    end
  end

  // Emission of the current run, clipped to what the plane can still take.
  always_comb begin
    if (phase_q == PH_PATLOAD) begin
      em_word = replicate_f(end_of_stream_i ? store_q : store_new, mask_q);
    end else if (phase_q == PH_LITERAL && !end_of_stream_i) begin
      em_word = {56'd0, stream_byte_i};
    end else begin
      em_word = '0;
    end
    em_n = (phase_q == PH_LITERAL && !end_of_stream_i) ? 8'd1 : run_left_q;
    n_eff = (CMP_W'(em_n) <= room) ? em_n : room[7:0];
    count_after = count_q + CNT_W'(n_eff);
    full_after  = (count_after == PLANE_C);
  end

  always_comb begin
    phase_d       = phase_q;
    prefix_left_d = prefix_left_q;
    run_left_d    = run_left_q;
    store_d       = store_q;
    mask_d        = mask_q;
    fill_d        = fill_q;
    count_d       = count_q;
    plane_d       = plane_q;
    push_o        = 1'b0;
    cmd_o         = '0;
    cmd_o.plane   = plane_q;
    rec_end       = 1'b0;
    rec_full      = 1'b0;

    case (phase_q)
      PH_PREFIX, PH_MARKER: begin
        if (accept) begin
          if (end_of_stream_i) begin
            push_o    = 1'b1;
            cmd_o.bad = 1'b1;
            phase_d   = PH_DONE;
          end else if (phase_q == PH_PREFIX && two_planes_i && prefix_left_q != '0) begin
            prefix_left_d = prefix_left_q - 1'b1;
          end else if (stream_byte_i == MARKER_BYTE) begin
            phase_d = PH_TAG;
          end else begin
            push_o    = 1'b1;
            cmd_o.bad = 1'b1;
            phase_d   = PH_DONE;
          end
        end
      end
      PH_TAG: begin
        if (accept) begin
          if (end_of_stream_i) begin
            phase_d = PH_FINAL;
          end else if (stream_byte_i[7]) begin
            mask_d     = pattern_mask_f(stream_byte_i[1:0]);
            run_left_d = {3'd0, stream_byte_i[6:2]};
            if (stream_byte_i[6:2] != 5'd0) begin
              store_d = '0;
              fill_d  = '0;
              phase_d = PH_PATLOAD;
            end else begin
              phase_d = PH_PATCNT;
            end
          end else if (stream_byte_i != 8'd0) begin
            run_left_d = stream_byte_i;
            phase_d    = PH_LITERAL;
          end else begin
            phase_d = PH_LITCNT;
          end
        end
      end
      PH_LITCNT: begin
        if (accept) begin
          if (end_of_stream_i) begin
            phase_d = PH_FINAL;
          end else begin
            run_left_d = stream_byte_i;
            if (stream_byte_i != 8'd0) begin
              phase_d = PH_LITERAL;
            end else begin
              rec_end  = 1'b1;
              rec_full = (count_q == PLANE_C);
            end
          end
        end
      end
      PH_PATCNT: begin
        if (accept) begin
          if (end_of_stream_i) begin
            phase_d = PH_FINAL;
          end else begin
            run_left_d = stream_byte_i;
            store_d    = '0;
            fill_d     = '0;
            phase_d    = PH_PATLOAD;
          end
        end
      end
      PH_PATLOAD, PH_LITERAL: begin
        if (accept) begin
          if (end_of_stream_i || phase_q == PH_LITERAL ||
              ({1'b0, fill_q[2:0]} + 4'd1) > {1'b0, mask_q}) begin
            push_o      = (n_eff != 8'd0);
            cmd_o.word  = em_word;
            cmd_o.len   = n_eff;
            cmd_o.pend  = full_after;
            cmd_o.pic   = full_after && last_plane;
            count_d     = count_after;
          end
          if (end_of_stream_i) begin
            run_left_d = 8'd0;
            phase_d    = PH_FINAL;
          end else if (phase_q == PH_LITERAL) begin
            run_left_d = run_left_q - 8'd1;
            if (run_left_q == 8'd1) begin
              rec_end  = 1'b1;
              rec_full = full_after;
            end
          end else begin
            store_d = store_new;
            fill_d  = fill_q + 4'd1;
            if (({1'b0, fill_q[2:0]} + 4'd1) > {1'b0, mask_q}) begin
              run_left_d = 8'd0;
              rec_end    = 1'b1;
              rec_full   = full_after;
            end
          end
        end
      end
      PH_FINAL: begin
        if (!queue_full_i) begin
          phase_d = PH_DONE;
          if (count_q != PLANE_C) begin
            push_o     = 1'b1;
            cmd_o.fill = 13'(room);
            cmd_o.pend = 1'b1;
            cmd_o.pic  = last_plane;
            cmd_o.bad  = !last_plane;
          end else if (!last_plane) begin
            push_o      = 1'b1;
            cmd_o.bad   = 1'b1;
            cmd_o.plane = 1'b1;
            plane_d     = 1'b1;
            count_d     = '0;
          end
        end
      end
      default: begin
      end
    endcase

    if (rec_end) begin
      if (rec_full) begin
        if (last_plane) begin
          phase_d = PH_DONE;
        end else begin
          plane_d = 1'b1;
          count_d = '0;
          phase_d = PH_MARKER;
        end
      end else begin
        phase_d = PH_TAG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_PREFIX;
      prefix_left_q <= PREF_W'(PREFIX_BYTES);
      run_left_q    <= '0;
      store_q       <= '0;
      mask_q        <= '0;
      fill_q        <= '0;
      count_q       <= '0;
      plane_q       <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      prefix_left_q <= prefix_left_d;
      run_left_q    <= run_left_d;
      store_q       <= store_d;
      mask_q        <= mask_d;
      fill_q        <= fill_d;
      count_q       <= count_d;
      plane_q       <= plane_d;
    end
  end

endmodule

// ----- sv/ppr_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// ppr_cmd_fifo: command queue between front end and back end
// Four entries deep; the head is visible to the back end without a pop.
// ----------------------------------------------------------------------------
module ppr_cmd_fifo
  import ppr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   used_q;
  logic              do_push, do_pop;

  assign full_o  = (used_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (used_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      used_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        used_q <= used_q + 1'b1;
      end else if (do_pop && !do_push) begin
        used_q <= used_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/ppr_back.sv -----
// ----------------------------------------------------------------------------
// ppr_back: chunk emitter of the packed picture run decoder
// Cuts the command at the queue head into results of up to eight bytes and
// holds each result in the output register until it is taken.
// ----------------------------------------------------------------------------
module ppr_back
  import ppr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  cmd_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic [12:0] zero_fill_o,
  output logic        plane_number_o,
  output logic        plane_end_o,
  output logic        picture_end_o,
  output logic        bad_marker_o
);

  logic        started_q;
  logic [7:0]  left_q;
  logic        valid_q;
  logic [63:0] bytes_q;
  logic [3:0]  count_q;
  logic [12:0] fill_q;
  logic        plane_q, pend_q, pic_q, bad_q;

  logic [7:0]  eff_len;
  logic [3:0]  cnt;
  logic        last;
  logic        load;

  assign eff_len = started_q ? left_q : head_i.len;
  assign cnt     = (eff_len >= CHUNK_BYTES) ? CHUNK_BYTES[3:0] : eff_len[3:0];
  assign last    = (eff_len <= CHUNK_BYTES);
  assign load    = head_valid_i && (!valid_q || !out_stall_i);
  assign pop_o   = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      left_q    <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (load) begin
        valid_q   <= 1'b1;
        started_q <= !last;
        left_q    <= eff_len - CHUNK_BYTES;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= keep_bytes_f(head_i.word, cnt);
      count_q <= cnt;
      fill_q  <= head_i.fill;
      plane_q <= head_i.plane;
      pend_q  <= last && head_i.pend;
      pic_q   <= last && head_i.pic;
      bad_q   <= head_i.bad;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_bytes_o    = bytes_q;
  assign byte_count_o   = count_q;
  assign zero_fill_o    = fill_q;
  assign plane_number_o = plane_q;
  assign plane_end_o    = pend_q;
  assign picture_end_o  = pic_q;
  assign bad_marker_o   = bad_q;

endmodule

// ----- sv/packed_picture_run_decoder.sv -----
// ----------------------------------------------------------------------------
// packed_picture_run_decoder: expands a packed picture into plane bytes
// A front end parses the byte stream and its run records, a back end turns
// each run into results of up to eight bytes, and a command queue sits
// between them so either side can stall without at once holding the other.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                Payload
//   --------  ---------  -----------------------  ----------------------------
//   input     in         in_valid_i / in_stall_o  stream_byte_i, end_of_stream_i
//   result    out        out_valid_o/out_stall_i  out_bytes_o, byte_count_o,
//                                                 zero_fill_o, plane_number_o,
//                                                 plane_end_o, picture_end_o,
//                                                 bad_marker_o
//   config    in         APB (pready tied high)   two_planes at any address
//
// Input requests are taken one per cycle while the command queue has room and
// no end of stream is being closed. A pattern run of n bytes leaves as
// ceil(n/8) results, one per cycle unless the output stalls, so long runs fill
// the four-entry queue and stall the input until an entry frees. An end of
// stream inside a plane stalls the input while the closing result is queued.
// Reset is asynchronous; a stalled result holds unchanged.
// ----------------------------------------------------------------------------
module packed_picture_run_decoder
  import ppr_pkg::*;
#(
  parameter int PLANE_BYTES  = 7680,
  parameter int PREFIX_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        end_of_stream_i,
  // Results.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic [12:0] zero_fill_o,
  output logic        plane_number_o,
  output logic        plane_end_o,
  output logic        picture_end_o,
  output logic        bad_marker_o
);

  logic two_planes_q;
  logic cfg_write;

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic queue_empty;
  logic pop;
  cmd_t head_cmd;

  // The only register fills the whole address space, so every address
  // within the word selects it.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[1:0] == paddr[1:0]);
  assign prdata    = {31'd0, two_planes_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_planes_q <= 1'b0;
    end else if (cfg_write) begin
      two_planes_q <= pwdata[0];
    end
  end

  // Front end: prefix skip, marker check, tag decode and plane accounting.
  ppr_front #(
    .PLANE_BYTES  (PLANE_BYTES),
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .two_planes_i    (two_planes_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .stream_byte_i   (stream_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  // Commands wait here until the back end has room to cut them up.
  ppr_cmd_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (queue_full),
    .pop_i       (pop),
    .empty_o     (queue_empty),
    .head_o      (head_cmd)
  );

  // Back end: one result per cycle, while not stalled, from the queue head.
  ppr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (!queue_empty),
    .head_i         (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_bytes_o    (out_bytes_o),
    .byte_count_o   (byte_count_o),
    .zero_fill_o    (zero_fill_o),
    .plane_number_o (plane_number_o),
    .plane_end_o    (plane_end_o),
    .picture_end_o  (picture_end_o),
    .bad_marker_o   (bad_marker_o)
  );

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench of the packed picture run decoder
// Builds one packed two-plane picture out of directed and random run records,
// feeds it through the valid/stall input under several idle and stall
// phases, predicts every result in the bench and checks each one field by
// field. The stream ends in one of several randomly chosen ways.
// ----------------------------------------------------------------------------
module tb;
  import ppr_pkg::*;

  localparam int PLANE_SIZE    = 7680;
  localparam int PREFIX_LEN    = 8;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_LIMIT   = 100000;
  localparam int HOLD_OFF_LEN  = 300;

  // Byte address of the only configuration register.
  localparam logic [1:0] TWO_PLANES_ADDR = 2'd0;

  // How the stream is brought to its end; the seed picks one per run.
  typedef enum int {
    END_NO_MARKER,
    END_BAD_MARKER,
    END_AT_BOUNDARY,
    END_MID_RECORD,
    END_FULL_PICTURE,
    END_CUT_PLANE0
  } ending_e;

  typedef struct packed {
    logic [7:0] value;
    logic       eos;
  } stream_item_t;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic [12:0] fill;
    logic        plane;
    logic        pend;
    logic        pic;
    logic        bad;
  } picture_result_t;

  // Clock, reset and every input of the block start at known values.
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [1:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  stream_byte_i   = '0;
  logic        end_of_stream_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [63:0] out_bytes_o;
  logic [3:0]  byte_count_o;
  logic [12:0] zero_fill_o;
  logic        plane_number_o;
  logic        plane_end_o;
  logic        picture_end_o;
  logic        bad_marker_o;

  packed_picture_run_decoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .stream_byte_i   (stream_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_bytes_o     (out_bytes_o),
    .byte_count_o    (byte_count_o),
    .zero_fill_o     (zero_fill_o),
    .plane_number_o  (plane_number_o),
    .plane_end_o     (plane_end_o),
    .picture_end_o   (picture_end_o),
    .bad_marker_o    (bad_marker_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bench bookkeeping.
  stream_item_t    stream_items[$];      // requests waiting to be offered
  picture_result_t expected_results[$];  // results predicted, not yet seen
  logic [7:0]      record_bytes[$];      // scratch for the record generator
  int              record_len;
  int              plane_fill_est;
  int              pushed_total     = 0;
  int              requests_sent    = 0;
  int              results_checked  = 0;
  int              fail_count       = 0;
  int              send_idle_pct    = 0;
  int              recv_stall_pct   = 0;
  int              hold_off_cycles  = 0;
  logic            req_taken        = 1'b0;
  ending_e         ending;

  // --------------------------------------------------------------------------
  // Decoder prediction. The bench keeps its own copy of the front-end state
  // and of the configuration register. Each accepted request appends the
  // results it causes, in order, to expected_results.
  // --------------------------------------------------------------------------
  logic        cfg_two_planes = 1'b0;
  phase_e      dec_phase      = PH_PREFIX;
  logic [3:0]  prefix_left    = 4'(PREFIX_LEN);
  logic [7:0]  run_left       = '0;
  logic [63:0] pat_word       = '0;
  logic [2:0]  pat_mask       = '0;
  logic [3:0]  pat_fill       = '0;
  int          plane_count    = 0;
  logic        cur_plane      = 1'b0;
  logic [63:0] chunk_data     = '0;
  logic [3:0]  chunk_len      = '0;

  // The current plane is the final one unless two planes are selected and
  // the first is still being decoded.
  function automatic logic final_plane();
    return !(cfg_two_planes && cur_plane == 1'b0);
  endfunction

  task automatic add_expected(input logic [63:0] data, input logic [3:0] count,
                              input logic [12:0] fill, input logic pend,
                              input logic pic, input logic bad);
    expected_results.push_back('{data, count, fill, cur_plane, pend, pic, bad});
  endtask

  task automatic flush_chunk();
    logic full;
    if (chunk_len != 0) begin
      full = plane_count >= PLANE_SIZE;
      add_expected(chunk_data, chunk_len, '0, full, full && final_plane(), 1'b0);
      chunk_data = '0;
      chunk_len  = '0;
    end
  endtask

  // Bytes past the end of the plane are swallowed without a trace.
  task automatic emit_byte(input logic [7:0] v);
    if (plane_count < PLANE_SIZE) begin
      chunk_data[8*chunk_len +: 8] = v;
      chunk_len++;
      plane_count++;
      if (chunk_len == 4'd8 || plane_count >= PLANE_SIZE) begin
        flush_chunk();
      end
    end
  endtask

  task automatic expand_pattern();
    logic [2:0] idx;
    idx = '0;
    while (run_left != 0) begin
      emit_byte(pat_word[8*idx +: 8]);
      idx = (idx + 3'd1) & pat_mask;
      run_left--;
    end
  endtask

  // At a record boundary a full plane either ends the picture or moves on
  // to the marker of the second plane.
  task automatic close_record();
    if (plane_count >= PLANE_SIZE) begin
      if (final_plane()) begin
        dec_phase = PH_DONE;
      end else begin
        cur_plane   = 1'b1;
        plane_count = 0;
        dec_phase   = PH_MARKER;
      end
    end else begin
      dec_phase = PH_TAG;
    end
  endtask

  task automatic begin_pattern();
    pat_word  = '0;
    pat_fill  = '0;
    dec_phase = PH_PATLOAD;
  endtask

  task automatic flag_bad_marker();
    add_expected('0, '0, '0, 1'b0, 1'b0, 1'b1);
    dec_phase = PH_DONE;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    case (dec_phase)
      PH_PREFIX, PH_MARKER: begin
        // The prefix is skipped only in two-plane mode; otherwise the byte
        // is already the plane marker.
        if (dec_phase == PH_PREFIX && cfg_two_planes && prefix_left != 0) begin
          prefix_left--;
        end else if (b == MARKER_BYTE) begin
          dec_phase = PH_TAG;
        end else begin
          flag_bad_marker();
        end
      end
      PH_TAG: begin
        if (b[7]) begin
          pat_mask = 3'((4'd1 << b[1:0]) - 4'd1);
          run_left = {3'b000, b[6:2]};
          if (run_left != 0) begin
            begin_pattern();
          end else begin
            dec_phase = PH_PATCNT;
          end
        end else if (b != 0) begin
          run_left  = b;
          dec_phase = PH_LITERAL;
        end else begin
          dec_phase = PH_LITCNT;
        end
      end
      PH_LITCNT: begin
        run_left = b;
        if (b != 0) begin
          dec_phase = PH_LITERAL;
        end else begin
          close_record();
        end
      end
      PH_PATCNT: begin
        run_left = b;
        begin_pattern();
      end
      PH_PATLOAD: begin
        // A zero-length pattern run still consumes its pattern bytes.
        pat_word = pat_word | (64'(b) << (8 * pat_fill[2:0]));
        pat_fill = pat_fill + 4'd1;
        if (pat_fill > {1'b0, pat_mask}) begin
          expand_pattern();
          close_record();
        end
      end
      PH_LITERAL: begin
        emit_byte(b);
        if (run_left != 0) run_left--;
        if (run_left == 0) close_record();
      end
      default: begin
      end
    endcase
  endtask

  task automatic predict_end_of_stream();
    logic is_final;
    case (dec_phase)
      PH_PREFIX, PH_MARKER: begin
        flag_bad_marker();
        return;
      end
      PH_PATLOAD: begin
        // Missing pattern bytes count as zeros, and the run is expanded.
        expand_pattern();
      end
      PH_LITERAL: begin
        while (run_left != 0) begin
          emit_byte(8'h00);
          run_left--;
        end
      end
      PH_DONE: begin
        return;
      end
      default: begin
      end
    endcase
    run_left = '0;
    flush_chunk();
    is_final = final_plane();
    if (plane_count < PLANE_SIZE) begin
      // Report the padding; a second plane that never comes is flagged too.
      add_expected('0, '0, 13'(PLANE_SIZE - plane_count), 1'b1, is_final, !is_final);
    end else if (!is_final) begin
      cur_plane   = 1'b1;
      plane_count = 0;
      add_expected('0, '0, '0, 1'b0, 1'b0, 1'b1);
    end
    dec_phase = PH_DONE;
  endtask

  task automatic predict_request(input logic [7:0] b, input logic eos);
    chunk_data = '0;
    chunk_len  = '0;
    if (eos) begin
      predict_end_of_stream();
    end else begin
      predict_byte(b);
    end
    flush_chunk();
  endtask

  // --------------------------------------------------------------------------
  // Input side. Requests change on the falling edge; the payload is held
  // while the block stalls. An accepted request is predicted at the rising
  // edge at which it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_request(stream_byte_i, end_of_stream_i);
      requests_sent++;
      req_taken <= 1'b1;
    end else begin
      req_taken <= 1'b0;
    end
  end

  always @(negedge clk_i) begin : drive_requests
    stream_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !req_taken) begin
      // Still waiting for the block to take the current request.
    end else if (stream_items.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
      nxt = stream_items.pop_front();
      in_valid_i      <= 1'b1;
      stream_byte_i   <= nxt.value;
      end_of_stream_i <= nxt.eos;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result side. The stall is random per cycle, except during a hold-off,
  // which keeps it high until hold_off_cycles counts down, so that the command
  // queue fills and the block stalls its input.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      out_stall_i <= $urandom_range(1, 100) <= recv_stall_pct;
    end
  end

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    picture_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no prediction pending: bytes %0h count %0d",
               out_bytes_o, byte_count_o);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("out_bytes", want.data, out_bytes_o);
        compare_field("byte_count", 64'(want.count), 64'(byte_count_o));
        compare_field("zero_fill", 64'(want.fill), 64'(zero_fill_o));
        compare_field("plane_number", 64'(want.plane), 64'(plane_number_o));
        compare_field("plane_end", 64'(want.pend), 64'(plane_end_o));
        compare_field("picture_end", 64'(want.pic), 64'(picture_end_o));
        compare_field("bad_marker", 64'(want.bad), 64'(bad_marker_o));
        results_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration access. A write is followed by a read-back of the same
  // register; the predictor takes the new value at the write edge.
  // --------------------------------------------------------------------------
  task automatic set_two_planes(input logic v);
    logic [31:0] got;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = TWO_PLANES_ADDR;
    pwdata  = 32'(v);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_two_planes = v;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    psel = 1'b1;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    compare_field("two_planes read-back", 64'(v), 64'(got));
  endtask

  // --------------------------------------------------------------------------
  // Stream construction. Records are well formed unless cut on purpose;
  // plane_fill_est tracks how many bytes the current plane has been given.
  // --------------------------------------------------------------------------
  task automatic push_stream_byte(input logic [7:0] b);
    stream_items.push_back('{b, 1'b0});
    pushed_total++;
  endtask

  task automatic push_end_of_stream();
    stream_items.push_back('{8'($urandom_range(0, 255)), 1'b1});
    pushed_total++;
  endtask

  // Literal runs are kept short since each byte costs a request; most of the
  // plane is filled by long pattern runs, mostly with short patterns.
  task automatic make_record();
    int r;
    int n;
    int w;
    logic [1:0] sel;
    r = $urandom_range(0, 99);
    record_bytes.delete();
    if (r < 15) begin
      n = $urandom_range(1, 6);
      record_bytes.push_back(8'(n));
      repeat (n) record_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (r < 22) begin
      n = $urandom_range(0, 6);
      record_bytes.push_back(8'h00);
      record_bytes.push_back(8'(n));
      repeat (n) record_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      w = $urandom_range(0, 99);
      sel = (w < 40) ? 2'd0 : (w < 70) ? 2'd1 : (w < 88) ? 2'd2 : 2'd3;
      if (r < 37) begin
        n = $urandom_range(1, 31);
        record_bytes.push_back({1'b1, 5'(n), sel});
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(160, 255);
        record_bytes.push_back({1'b1, 5'b00000, sel});
        record_bytes.push_back(8'(n));
      end
      repeat (1 << sel) record_bytes.push_back(8'($urandom_range(0, 255)));
    end
    record_len = n;
  endtask

  task automatic add_record();
    make_record();
    foreach (record_bytes[i]) push_stream_byte(record_bytes[i]);
    plane_fill_est += record_len;
  endtask

  // Sends only part of a record, then ends the stream inside it.
  task automatic add_cut_record();
    int keep;
    make_record();
    keep = $urandom_range(1, record_bytes.size() - 1);
    for (int i = 0; i < keep; i++) push_stream_byte(record_bytes[i]);
    push_end_of_stream();
  endtask

  task automatic add_ignored_tail();
    repeat (3) push_stream_byte(8'($urandom_range(0, 255)));
    push_end_of_stream();
  endtask

  // Waits until every request has been taken and every predicted result
  // has come out, then lets the block settle before anything else happens.
  task automatic wait_for_idle();
    int guard;
    guard = 0;
    while (!(stream_items.size() == 0 && !in_valid_i && expected_results.size() == 0)
           && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      fail_count++;
      expected_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence. One picture is decoded per run since reset is applied
  // only once; the phases below differ in idling and stall behavior.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int start_count;
    ending = ending_e'($urandom_range(0, 5));
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening with two planes selected: the prefix with the byte
    // extremes, the marker, zero-length literal and pattern runs, a short
    // literal and the longest short-form pattern run with an 8-byte pattern.
    set_two_planes(1'b1);
    push_stream_byte(8'h00);
    push_stream_byte(8'hFF);
    repeat (PREFIX_LEN - 2) push_stream_byte(8'($urandom_range(0, 255)));
    push_stream_byte(MARKER_BYTE);
    push_stream_byte(8'h00);
    push_stream_byte(8'h00);
    push_stream_byte(8'h02);
    push_stream_byte(8'h00);
    push_stream_byte(8'hFF);
    push_stream_byte(8'h80);
    push_stream_byte(8'h00);
    push_stream_byte(8'($urandom_range(0, 255)));
    push_stream_byte(8'hFF);
    repeat (8) push_stream_byte(8'($urandom_range(0, 255)));
    plane_fill_est = 2 + 31;
    wait_for_idle();

    // Both register values while idle mid-plane; only a plane boundary or
    // the end of the stream looks at the setting, so the picture goes on.
    set_two_planes(1'b0);
    set_two_planes(1'b1);

    // Sender idle most of the time.
    send_idle_pct = 66;
    start_count   = pushed_total;
    while (pushed_total - start_count < 70 && plane_fill_est < PLANE_SIZE - 300) begin
      add_record();
    end
    wait_for_idle();

    // Receiver stalls most of the time, opening with a long hold-off while
    // the sender keeps offering, so the block backs up to its input.
    send_idle_pct   = 0;
    recv_stall_pct  = 66;
    hold_off_cycles = HOLD_OFF_LEN;
    if (ending == END_CUT_PLANE0) begin
      // The cut record may or may not complete the first plane.
      while (plane_fill_est < PLANE_SIZE - 100) add_record();
      add_cut_record();
    end else begin
      while (plane_fill_est < PLANE_SIZE) add_record();
    end
    wait_for_idle();

    // Second plane, both sides idling now and then. The register can take
    // either value here since the second plane is always the final one.
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    set_two_planes(1'($urandom_range(0, 1)));
    plane_fill_est = 0;
    case (ending)
      END_NO_MARKER: begin
        push_end_of_stream();
      end
      END_BAD_MARKER: begin
        push_stream_byte(8'($urandom_range(0, 254)));
        add_ignored_tail();
      end
      END_AT_BOUNDARY: begin
        push_stream_byte(MARKER_BYTE);
        repeat ($urandom_range(4, 12)) add_record();
        push_end_of_stream();
      end
      END_MID_RECORD: begin
        push_stream_byte(MARKER_BYTE);
        repeat ($urandom_range(4, 12)) add_record();
        add_cut_record();
      end
      END_FULL_PICTURE: begin
        push_stream_byte(MARKER_BYTE);
        while (plane_fill_est < PLANE_SIZE) add_record();
        add_ignored_tail();
      end
      default: begin
        // The picture already ended in the first plane.
        add_ignored_tail();
      end
    endcase
    wait_for_idle();

    $display("Decoded %0d stream requests into %0d checked results across prefix,",
             requests_sent, results_checked);
    $display("both planes, idle and stall phases and a hold-off; ending %s.", ending.name());
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- packed_picture_run_decoder.f -----
sv/ppr_pkg.sv
sv/ppr_front.sv
sv/ppr_cmd_fifo.sv
sv/ppr_back.sv
sv/packed_picture_run_decoder.sv
verif/tb.sv
